@@ rtl/evs_pkg.sv @@
`default_nettype none

package evs_pkg;

	localparam int FRAME_SAMPLES = 400;

	localparam int IDX_W   = $clog2(FRAME_SAMPLES);
	localparam int FILL_W  = $clog2(FRAME_SAMPLES + 1);
	localparam int CROSS_W = $clog2(FRAME_SAMPLES);
	// one square is at most 2^30, so the window sum needs 31 + log2(depth) bits
	localparam int SUM_W   = 31 + $clog2(FRAME_SAMPLES);

	localparam int SAMPLE_W   = 16;
	localparam int SQUARE_W   = 31;
	localparam int ENERGY_W   = 39;
	localparam int CROSS_OUT_W = 9;
	localparam int POS_W      = 32;
	localparam int HOP_W      = 9;
	localparam int COUNT_W    = 16;
	localparam int STATUS_W   = 2;

	localparam int ECMP_W = (SUM_W > ENERGY_W) ? SUM_W : ENERGY_W;
	localparam int CCMP_W = (CROSS_W > 12) ? CROSS_W : 12;

	localparam int DIV_STEPS = POS_W;
	localparam int DIV_CNT_W = $clog2(DIV_STEPS);

	localparam int TDATA_W = 232;
	localparam int TUSER_W = 2;

	localparam int APB_ADDR_W = 6;
	localparam int APB_DATA_W = 64;
	localparam int REG_IDX_W  = 3;

	localparam logic [REG_IDX_W-1:0] REG_ENERGY_THR = 3'd0;
	localparam logic [REG_IDX_W-1:0] REG_ENERGY_FLR = 3'd1;
	localparam logic [REG_IDX_W-1:0] REG_CROSS_THR  = 3'd2;
	localparam logic [REG_IDX_W-1:0] REG_CROSS_FLR  = 3'd3;
	localparam logic [REG_IDX_W-1:0] REG_HOP        = 3'd4;
	localparam logic [REG_IDX_W-1:0] REG_MIN_SEG    = 3'd5;
	localparam logic [REG_IDX_W-1:0] REG_SEG_LIMIT  = 3'd6;

	localparam logic [STATUS_W-1:0] STATUS_RUN   = 2'd0;
	localparam logic [STATUS_W-1:0] STATUS_DONE  = 2'd1;
	localparam logic [STATUS_W-1:0] STATUS_SHORT = 2'd2;

	function automatic logic [IDX_W-1:0] next_idx(input logic [IDX_W-1:0] i);
		next_idx = (i == IDX_W'(FRAME_SAMPLES - 1)) ? '0 : i + IDX_W'(1);
	endfunction

endpackage

`default_nettype wire

@@ rtl/evs_window_ram.sv @@
`default_nettype none

module evs_window_ram (
	input  wire logic                             clk,
	input  wire logic                             we,
	input  wire logic [evs_pkg::IDX_W-1:0]        waddr,
	input  wire logic signed [evs_pkg::SAMPLE_W-1:0] wdata,
	input  wire logic [evs_pkg::IDX_W-1:0]        raddr,
	output logic signed [evs_pkg::SAMPLE_W-1:0]   rdata
);

	logic signed [evs_pkg::SAMPLE_W-1:0] mem [evs_pkg::FRAME_SAMPLES];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule

`default_nettype wire

@@ rtl/evs_div.sv @@
`default_nettype none

// restoring divider, one quotient bit per cycle
module evs_div (
	input  wire logic                           clk,
	input  wire logic                           arst_n,
	input  wire logic                           start,
	input  wire logic [evs_pkg::POS_W-1:0]      dividend,
	input  wire logic [evs_pkg::HOP_W-1:0]      divisor,
	output logic                                done,
	output logic [evs_pkg::POS_W-1:0]           quotient
);

	logic                             busy_q;
	logic [evs_pkg::DIV_CNT_W-1:0]    cnt_q;
	logic [evs_pkg::HOP_W-1:0]        den_q;
	logic [evs_pkg::HOP_W-1:0]        rem_q;
	logic [evs_pkg::POS_W-1:0]        quo_q;
	logic                             done_q;
	logic [evs_pkg::HOP_W:0]          rem_sh;
	logic                             fits;

	always_comb begin
		rem_sh = {rem_q, quo_q[evs_pkg::POS_W-1]};
		fits   = rem_sh >= {1'b0, den_q};
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
			den_q  <= '0;
			rem_q  <= '0;
			quo_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= evs_pkg::DIV_CNT_W'(evs_pkg::DIV_STEPS - 1);
				den_q  <= divisor;
				rem_q  <= '0;
				quo_q  <= dividend;
			end else if (busy_q) begin
				rem_q <= fits ? evs_pkg::HOP_W'(rem_sh - {1'b0, den_q})
				              : rem_sh[evs_pkg::HOP_W-1:0];
				quo_q <= {quo_q[evs_pkg::POS_W-2:0], fits};
				if (cnt_q == '0) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end else begin
					cnt_q <= cnt_q - 1'b1;
				end
			end
		end
	end

	assign done     = done_q;
	assign quotient = quo_q;

endmodule

`default_nettype wire

@@ rtl/energy_zcr_voice_activity_segmenter.sv @@
// Voice activity segmenter on signed 16-bit audio.
// Input stream: s_tdata carries one sample, s_tlast marks the final sample of a
// stream; that transfer flushes an open segment and clears the stream state but prev_q.
// Output stream: at most one result per sample, given when the sample completes
// a frame decision, closes a reported segment or carries s_tlast. m_tuser tells
// which of frame and segment fields are meaningful.
// Timing: a sample passes ST_RD, ST_ACC, ST_UPD, ST_JUDGE and ST_EMIT, where its
// result, if any, is registered, and s_tready rises again at that same edge, so a
// new sample is taken only after the last one is through. A sample that closes a
// segment also waits in ST_DIV for the bit-serial length/hop divider. The window
// lives in a single-port-read RAM, so the oldest and next-oldest samples are
// fetched one after the other. A result waits in the output register while the
// next sample is accepted and processed; only a second result stalls the block
// until m_tready.
// Reset: asynchronous, clears the stream state and loads default register
// values; window RAM contents are never used before being written.
// Configuration goes through the APB port, 64-bit registers at 8-byte steps.
`default_nettype none

module energy_zcr_voice_activity_segmenter (
	input  wire logic                            clk,
	input  wire logic                            arst_n,
	input  wire logic                            s_tvalid,
	output logic                                 s_tready,
	input  wire logic [evs_pkg::SAMPLE_W-1:0]    s_tdata,  // sample
	input  wire logic                            s_tlast,  // last_sample
	output logic                                 m_tvalid,
	input  wire logic                            m_tready,
	// frame_is_speech, frame_energy, frame_crossings, segment_start,
	// segment_end, segment_length, segment_hops, segments_so_far,
	// speech_frames_so_far, stream_status, zero padding
	output logic [evs_pkg::TDATA_W-1:0]          m_tdata,
	output logic [evs_pkg::TUSER_W-1:0]          m_tuser,  // frame_done, segment_valid
	input  wire logic                            psel,
	input  wire logic                            penable,
	input  wire logic                            pwrite,
	input  wire logic [evs_pkg::APB_ADDR_W-1:0]  paddr,
	input  wire logic [evs_pkg::APB_DATA_W-1:0]  pwdata,
	output logic [evs_pkg::APB_DATA_W-1:0]       prdata,
	output logic                                 pready
);

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_RD,
		ST_ACC,
		ST_UPD,
		ST_JUDGE,
		ST_DIV,
		ST_EMIT
	} state_t;

	state_t state_q;

	// configuration
	logic [evs_pkg::ENERGY_W-1:0] thr_q, floor_q;
	logic [9:0]                   ct_q;
	logic [11:0]                  cf_q;
	logic [evs_pkg::HOP_W-1:0]    hop_q;
	logic [evs_pkg::COUNT_W-1:0]  minseg_q, limit_q;

	// stream state
	logic [evs_pkg::SUM_W-1:0]    energy_q;
	logic [evs_pkg::CROSS_W-1:0]  cross_q;
	logic [evs_pkg::POS_W-1:0]    pos_q;
	logic [evs_pkg::HOP_W-1:0]    hop_cnt_q;
	logic                         open_q;
	logic [evs_pkg::POS_W-1:0]    start_q, end_q;
	logic [evs_pkg::COUNT_W-1:0]  reported_q;
	logic [evs_pkg::POS_W-1:0]    speech_tot_q;
	logic [evs_pkg::FILL_W-1:0]   fill_q;
	logic [evs_pkg::IDX_W-1:0]    wr_q;
	logic signed [evs_pkg::SAMPLE_W-1:0] prev_q;

	// per-sample working registers
	logic signed [evs_pkg::SAMPLE_W-1:0] sample_q, old_q, nxt_q;
	logic                         last_q;
	logic [evs_pkg::SQUARE_W-1:0] prod_q;
	logic                         judge_q;
	logic                         fdone_q, fspeech_q;
	logic [evs_pkg::ENERGY_W-1:0] fenergy_q;
	logic [evs_pkg::CROSS_OUT_W-1:0] fcross_q;
	logic                         segv_q;
	logic [evs_pkg::POS_W-1:0]    cstart_q, cend_q, clen_q, cframes_q;

	// output register
	logic                         m_tvalid_q;
	logic [evs_pkg::TDATA_W-1:0]  m_tdata_q;
	logic [evs_pkg::TUSER_W-1:0]  m_tuser_q;

	// window RAM
	logic                                ram_we;
	logic [evs_pkg::IDX_W-1:0]           ram_raddr;
	logic signed [evs_pkg::SAMPLE_W-1:0] ram_rdata;

	// divider
	logic                        div_start;
	logic                        div_done;
	logic [evs_pkg::POS_W-1:0]   div_quo;

	logic                        in_xfer, out_free, cfg_wr;
	logic [evs_pkg::REG_IDX_W-1:0] cfg_idx;
	logic [evs_pkg::HOP_W-1:0]   hop_eff;
	logic                        full;
	logic signed [31:0]          prod_c;
	logic signed [evs_pkg::SAMPLE_W-1:0] mul_op;
	logic                        d_new, d_old;
	logic [evs_pkg::HOP_W:0]     hop_inc;
	logic [evs_pkg::ECMP_W-1:0]  e_w, thr_w, flr_w;
	logic [evs_pkg::CCMP_W-1:0]  z_w, ct4_w, cf_w;
	logic                        speech_c, close_c, need_out;
	logic [evs_pkg::POS_W-1:0]   fstart_c, cstart_c, cend_c;
	logic [evs_pkg::STATUS_W-1:0] status_c;

	evs_window_ram u_ram (
		.clk   (clk),
		.we    (ram_we),
		.waddr (wr_q),
		.wdata (sample_q),
		.raddr (ram_raddr),
		.rdata (ram_rdata)
	);

	evs_div u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (div_start),
		.dividend (cend_c - cstart_c),
		.divisor  (hop_eff),
		.done     (div_done),
		.quotient (div_quo)
	);

	always_comb begin
		in_xfer  = s_tvalid && s_tready;
		out_free = !m_tvalid_q || m_tready;
		cfg_wr   = psel && penable && pwrite && pready;
		cfg_idx  = paddr[evs_pkg::APB_ADDR_W-1:3];
		hop_eff  = (hop_q == '0) ? evs_pkg::HOP_W'(1) : hop_q;
		full     = fill_q == evs_pkg::FILL_W'(evs_pkg::FRAME_SAMPLES);

		ram_we    = state_q == ST_UPD;
		ram_raddr = (state_q == ST_RD) ? evs_pkg::next_idx(wr_q) : wr_q;

		mul_op = (state_q == ST_RD) ? sample_q : old_q;
		prod_c = 32'(mul_op) * 32'(mul_op);

		d_new   = (fill_q != '0) && (prev_q[evs_pkg::SAMPLE_W-1] != sample_q[evs_pkg::SAMPLE_W-1]);
		d_old   = full && (old_q[evs_pkg::SAMPLE_W-1] != nxt_q[evs_pkg::SAMPLE_W-1]);
		hop_inc = {1'b0, hop_cnt_q} + 1'b1;

		e_w   = evs_pkg::ECMP_W'(energy_q);
		thr_w = evs_pkg::ECMP_W'(thr_q);
		flr_w = evs_pkg::ECMP_W'(floor_q);
		z_w   = evs_pkg::CCMP_W'(cross_q);
		ct4_w = evs_pkg::CCMP_W'({ct_q, 2'b00});
		cf_w  = evs_pkg::CCMP_W'(cf_q);
		speech_c = (e_w >= flr_w) && (e_w > thr_w) && !(z_w > ct4_w)
		           && !((e_w < flr_w) && (z_w < cf_w));

		fstart_c = pos_q - evs_pkg::POS_W'(evs_pkg::FRAME_SAMPLES);
		cstart_c = (judge_q && speech_c && !open_q) ? fstart_c : start_q;
		cend_c   = (judge_q && speech_c) ? pos_q : end_q;
		close_c  = (judge_q && !speech_c && open_q)
		           || (last_q && (open_q || (judge_q && speech_c)));
		div_start = (state_q == ST_JUDGE) && close_c;

		need_out = fdone_q || segv_q || last_q;
		if (!last_q) begin
			status_c = evs_pkg::STATUS_RUN;
		end else if (full) begin
			status_c = evs_pkg::STATUS_DONE;
		end else begin
			status_c = evs_pkg::STATUS_SHORT;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= ST_IDLE;
			thr_q        <= evs_pkg::ENERGY_W'(59500000);
			floor_q      <= evs_pkg::ENERGY_W'(100000);
			ct_q         <= 10'd28;
			cf_q         <= 12'd15;
			hop_q        <= evs_pkg::HOP_W'(160);
			minseg_q     <= 16'd10;
			limit_q      <= 16'd32;
			energy_q     <= '0;
			cross_q      <= '0;
			pos_q        <= '0;
			hop_cnt_q    <= '0;
			open_q       <= 1'b0;
			start_q      <= '0;
			end_q        <= '0;
			reported_q   <= '0;
			speech_tot_q <= '0;
			fill_q       <= '0;
			wr_q         <= '0;
			prev_q       <= '0;
			sample_q     <= '0;
			old_q        <= '0;
			nxt_q        <= '0;
			last_q       <= 1'b0;
			prod_q       <= '0;
			judge_q      <= 1'b0;
			fdone_q      <= 1'b0;
			fspeech_q    <= 1'b0;
			fenergy_q    <= '0;
			fcross_q     <= '0;
			segv_q       <= 1'b0;
			cstart_q     <= '0;
			cend_q       <= '0;
			clen_q       <= '0;
			cframes_q    <= '0;
			m_tvalid_q   <= 1'b0;
			m_tdata_q    <= '0;
			m_tuser_q    <= '0;
		end else begin
			if (cfg_wr) begin
				case (cfg_idx)
					evs_pkg::REG_ENERGY_THR: thr_q    <= pwdata[evs_pkg::ENERGY_W-1:0];
					evs_pkg::REG_ENERGY_FLR: floor_q  <= pwdata[evs_pkg::ENERGY_W-1:0];
					evs_pkg::REG_CROSS_THR:  ct_q     <= pwdata[9:0];
					evs_pkg::REG_CROSS_FLR:  cf_q     <= pwdata[11:0];
					evs_pkg::REG_HOP:        hop_q    <= pwdata[evs_pkg::HOP_W-1:0];
					evs_pkg::REG_MIN_SEG:    minseg_q <= pwdata[15:0];
					evs_pkg::REG_SEG_LIMIT:  limit_q  <= pwdata[15:0];
					default: ;
				endcase
			end

			if (m_tvalid_q && m_tready) begin
				m_tvalid_q <= 1'b0;
			end

			case (state_q)
				ST_IDLE: begin
					if (in_xfer) begin
						sample_q <= s_tdata;
						last_q   <= s_tlast;
						state_q  <= ST_RD;
					end
				end
				ST_RD: begin
					old_q   <= ram_rdata;
					prod_q  <= prod_c[evs_pkg::SQUARE_W-1:0];
					state_q <= ST_ACC;
				end
				ST_ACC: begin
					nxt_q    <= ram_rdata;
					energy_q <= energy_q + evs_pkg::SUM_W'(prod_q);
					prod_q   <= prod_c[evs_pkg::SQUARE_W-1:0];
					state_q  <= ST_UPD;
				end
				ST_UPD: begin
					if (full) begin
						energy_q <= energy_q - evs_pkg::SUM_W'(prod_q);
					end
					cross_q <= cross_q + evs_pkg::CROSS_W'(d_new) - evs_pkg::CROSS_W'(d_old);
					prev_q  <= sample_q;
					wr_q    <= evs_pkg::next_idx(wr_q);
					pos_q   <= pos_q + 1'b1;
					if (!full) begin
						fill_q  <= fill_q + 1'b1;
						judge_q <= (fill_q + 1'b1) == evs_pkg::FILL_W'(evs_pkg::FRAME_SAMPLES);
						hop_cnt_q <= '0;
					end else if (hop_inc >= {1'b0, hop_eff}) begin
						judge_q   <= 1'b1;
						hop_cnt_q <= '0;
					end else begin
						judge_q   <= 1'b0;
						hop_cnt_q <= hop_inc[evs_pkg::HOP_W-1:0];
					end
					state_q <= ST_JUDGE;
				end
				ST_JUDGE: begin
					fdone_q   <= judge_q;
					fspeech_q <= judge_q && speech_c;
					fenergy_q <= '0;
					fcross_q  <= '0;
					segv_q    <= 1'b0;
					if (judge_q) begin
						fenergy_q <= (e_w > evs_pkg::ECMP_W'({evs_pkg::ENERGY_W{1'b1}}))
						             ? {evs_pkg::ENERGY_W{1'b1}}
						             : e_w[evs_pkg::ENERGY_W-1:0];
						fcross_q  <= (z_w > evs_pkg::CCMP_W'({evs_pkg::CROSS_OUT_W{1'b1}}))
						             ? {evs_pkg::CROSS_OUT_W{1'b1}}
						             : z_w[evs_pkg::CROSS_OUT_W-1:0];
						if (speech_c) begin
							speech_tot_q <= speech_tot_q + 1'b1;
							open_q  <= 1'b1;
							start_q <= cstart_c;
							end_q   <= pos_q;
						end
					end
					cstart_q <= cstart_c;
					cend_q   <= cend_c;
					clen_q   <= cend_c - cstart_c;
					if (close_c) begin
						open_q  <= 1'b0;
						start_q <= '0;
						end_q   <= '0;
						state_q <= ST_DIV;
					end else begin
						state_q <= ST_EMIT;
					end
				end
				ST_DIV: begin
					if (div_done) begin
						cframes_q <= div_quo;
						if ((div_quo >= evs_pkg::POS_W'(minseg_q)) && (reported_q < limit_q)) begin
							segv_q     <= 1'b1;
							reported_q <= reported_q + 1'b1;
						end
						state_q <= ST_EMIT;
					end
				end
				ST_EMIT: begin
					if (!need_out) begin
						state_q <= ST_IDLE;
					end else if (out_free) begin
						m_tvalid_q <= 1'b1;
						m_tuser_q  <= {segv_q, fdone_q};
						m_tdata_q  <= {5'b0, status_c, speech_tot_q, reported_q,
						               segv_q ? cframes_q : '0,
						               segv_q ? clen_q : '0,
						               segv_q ? cend_q : '0,
						               segv_q ? cstart_q : '0,
						               fcross_q, fenergy_q, fspeech_q};
						if (last_q) begin
							energy_q     <= '0;
							cross_q      <= '0;
							pos_q        <= '0;
							hop_cnt_q    <= '0;
							open_q       <= 1'b0;
							start_q      <= '0;
							end_q        <= '0;
							reported_q   <= '0;
							speech_tot_q <= '0;
							fill_q       <= '0;
							wr_q         <= '0;
						end
						state_q <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	always_comb begin
		case (cfg_idx)
			evs_pkg::REG_ENERGY_THR: prdata = evs_pkg::APB_DATA_W'(thr_q);
			evs_pkg::REG_ENERGY_FLR: prdata = evs_pkg::APB_DATA_W'(floor_q);
			evs_pkg::REG_CROSS_THR:  prdata = evs_pkg::APB_DATA_W'(ct_q);
			evs_pkg::REG_CROSS_FLR:  prdata = evs_pkg::APB_DATA_W'(cf_q);
			evs_pkg::REG_HOP:        prdata = evs_pkg::APB_DATA_W'(hop_q);
			evs_pkg::REG_MIN_SEG:    prdata = evs_pkg::APB_DATA_W'(minseg_q);
			evs_pkg::REG_SEG_LIMIT:  prdata = evs_pkg::APB_DATA_W'(limit_q);
			default:                 prdata = '0;
		endcase
	end

	assign pready   = 1'b1;
	assign s_tready = state_q == ST_IDLE;
	assign m_tvalid = m_tvalid_q;
	assign m_tdata  = m_tdata_q;
	assign m_tuser  = m_tuser_q;

endmodule

`default_nettype wire
